### hdl/pot_pkg.sv
`timescale 1ns / 1ps
package pot_pkg;

  localparam int unsigned FRAMES_DEF  = 65536;
  localparam int unsigned HOST_ID_DEF = 0;
  localparam int unsigned IDX_W       = 24;  // enough for the largest table

  localparam logic [7:0]  DEVICE_OWNER = 8'd255;
  localparam logic [15:0] SMMU_MARK    = 16'hFFFF;
  localparam logic [35:0] GFN_NONE     = 36'hF_FFFF_FFFF;

  localparam logic [15:0] SHARE_LIMIT_RST = 16'd100;
  localparam logic [15:0] SMMU_LIMIT_RST  = 16'd16;

  localparam logic CFG_SHARE_LIMIT = 1'b0;
  localparam logic CFG_SMMU_LIMIT  = 1'b1;

  localparam logic [1:0] STAT_APPLIED  = 2'd0;
  localparam logic [1:0] STAT_NOCHANGE = 2'd1;
  localparam logic [1:0] STAT_FAULT    = 2'd2;

  typedef enum logic [3:0] {
    CMD_HOST_MAP    = 4'd0,
    CMD_IO_MAP      = 4'd1,
    CMD_CLEAR       = 4'd2,
    CMD_ASSIGN_VM   = 4'd3,
    CMD_GRANT       = 4'd4,
    CMD_REVOKE      = 4'd5,
    CMD_ASSIGN_SMMU = 4'd6,
    CMD_SMMU_MAP    = 4'd7,
    CMD_SMMU_UNMAP  = 4'd8
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [3:0]       cmd;
    logic [7:0]       vm;
    logic             in_range;
    logic [IDX_W-1:0] idx;
    logic [35:0]      gfn;
  } item_t;

  typedef struct packed {
    logic [7:0]  owner;
    logic [15:0] count;
    logic [35:0] gmap;
  } entry_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        write_stage2;
    logic        stage2_kind;
    logic        clear_host_mapping;
    logic        scrub_page;
    logic        fetch_contents;
    logic        flush_page;
    logic        write_smmu_entry;
    logic [7:0]  owner_after;
    logic [15:0] count_after;
  } result_t;

endpackage

### hdl/page_ownership_tracker_unit.sv
`timescale 1ns / 1ps
// Page ownership tracker: one entry (owner, share count, guest frame) per
// physical frame in a single-port-write RAM. After reset the table is swept
// to its initial contents, with full held high. A command then passes the
// execution unit as a RAM read followed by a decide and write back; a
// two-deep input queue and a one-deep result register let both sides
// stall on their own. Frames beyond the table read as unowned device memory
// and are never written.
module page_ownership_tracker_unit #(
  parameter int unsigned FRAMES  = pot_pkg::FRAMES_DEF,
  parameter int unsigned HOST_ID = pot_pkg::HOST_ID_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [3:0]  command,
  input  logic [7:0]  vm_id,
  input  logic [35:0] frame,
  input  logic [35:0] guest_frame,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic        write_stage2,
  output logic        stage2_kind,
  output logic        clear_host_mapping,
  output logic        scrub_page,
  output logic        fetch_contents,
  output logic        flush_page,
  output logic        write_smmu_entry,
  output logic [7:0]  owner_after,
  output logic [15:0] count_after
);
  import pot_pkg::*;

  logic        clearing, q_valid, q_pop, res_valid;
  item_t       q_item;
  result_t     res;
  logic [15:0] share_limit, smmu_ref_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      share_limit    <= SHARE_LIMIT_RST;
      smmu_ref_limit <= SMMU_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SHARE_LIMIT: share_limit    <= cfg_data;
        CFG_SMMU_LIMIT:  smmu_ref_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  pot_front #(.FRAMES(FRAMES)) u_front (
    .clk         (clk),
    .rst         (rst),
    .hold        (clearing),
    .push        (push),
    .full        (full),
    .command     (command),
    .vm_id       (vm_id),
    .frame       (frame),
    .guest_frame (guest_frame),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  pot_back #(.FRAMES(FRAMES), .HOST_ID(HOST_ID)) u_back (
    .clk            (clk),
    .rst            (rst),
    .clearing       (clearing),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .share_limit    (share_limit),
    .smmu_ref_limit (smmu_ref_limit),
    .res_valid      (res_valid),
    .res            (res),
    .pop            (pop)
  );

  assign empty              = !res_valid;
  assign status             = res.status;
  assign write_stage2       = res.write_stage2;
  assign stage2_kind        = res.stage2_kind;
  assign clear_host_mapping = res.clear_host_mapping;
  assign scrub_page         = res.scrub_page;
  assign fetch_contents     = res.fetch_contents;
  assign flush_page         = res.flush_page;
  assign write_smmu_entry   = res.write_smmu_entry;
  assign owner_after        = res.owner_after;
  assign count_after        = res.count_after;

endmodule

### hdl/pot_ram.sv
`timescale 1ns / 1ps
module pot_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/pot_front.sv
`timescale 1ns / 1ps
module pot_front #(
  parameter int unsigned FRAMES = pot_pkg::FRAMES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          hold,
  input  logic          push,
  output logic          full,
  input  logic [3:0]    command,
  input  logic [7:0]    vm_id,
  input  logic [35:0]   frame,
  input  logic [35:0]   guest_frame,
  output logic          q_valid,
  output pot_pkg::item_t q_item,
  input  logic          q_pop
);
  import pot_pkg::*;

  localparam int unsigned AW = $clog2(FRAMES);

  item_t      slots [2];
  logic       wptr, rptr;
  logic [1:0] fill;
  item_t      cls;
  logic       do_push;

  // classify: range check and table index
  always_comb begin
    cls.cmd      = command;
    cls.vm       = vm_id;
    cls.in_range = (frame < 36'(FRAMES));
    cls.idx      = '0;
    cls.idx[AW-1:0] = frame[AW-1:0];
    cls.gfn      = guest_frame;
  end

  assign full    = hold || (fill == 2'd2);
  assign do_push = push && !full;
  assign q_valid = (fill != 2'd0);
  assign q_item  = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= cls;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (q_pop) rptr <= ~rptr;
      fill <= fill + 2'(do_push) - 2'(q_pop);
    end
  end

endmodule

### hdl/pot_back.sv
`timescale 1ns / 1ps
module pot_back #(
  parameter int unsigned FRAMES  = pot_pkg::FRAMES_DEF,
  parameter int unsigned HOST_ID = pot_pkg::HOST_ID_DEF
) (
  input  logic             clk,
  input  logic             rst,
  output logic             clearing,
  input  logic             q_valid,
  input  pot_pkg::item_t   q_item,
  output logic             q_pop,
  input  logic [15:0]      share_limit,
  input  logic [15:0]      smmu_ref_limit,
  output logic             res_valid,
  output pot_pkg::result_t res,
  input  logic             pop
);
  import pot_pkg::*;

  localparam int unsigned AW = $clog2(FRAMES);
  localparam logic [7:0]  HOST = 8'(HOST_ID);

  state_t        state, state_next;
  item_t         cur;
  logic [AW-1:0] clr_addr;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;
  entry_t        ent, nent;
  result_t       dec;
  logic          go, out_free;

  pot_ram #(.WIDTH($bits(entry_t)), .DEPTH(FRAMES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign clearing  = (state == ST_CLEAR);
  assign out_free  = !res_valid || pop;
  assign ram_raddr = (state == ST_IDLE) ? q_item.idx[AW-1:0] : cur.idx[AW-1:0];

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    go         = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(FRAMES - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          go         = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // decide on the entry read for the current command
  always_comb begin
    if (cur.in_range) begin
      ent = ram_rdata;
    end else begin
      ent.owner = DEVICE_OWNER;
      ent.count = 16'd0;
      ent.gmap  = GFN_NONE;
    end
    nent = ent;
    dec  = '0;
    dec.status = STAT_NOCHANGE;
    case (cur.cmd)
      CMD_HOST_MAP: begin
        if (ent.owner == DEVICE_OWNER) begin
          dec.status = STAT_APPLIED; dec.write_stage2 = 1'b1;
        end else if (ent.owner == HOST || ent.count != 16'd0) begin
          dec.status = STAT_APPLIED; dec.write_stage2 = 1'b1; dec.stage2_kind = 1'b1;
        end else begin
          dec.status = STAT_FAULT;
        end
      end
      CMD_IO_MAP: begin
        if (ent.owner == DEVICE_OWNER) begin
          dec.status = STAT_APPLIED; dec.write_stage2 = 1'b1;
        end
      end
      CMD_CLEAR: begin
        if (ent.owner == cur.vm) begin
          dec.status = STAT_APPLIED;
          nent.owner = HOST; nent.count = 16'd0; nent.gmap = 36'd0;
          dec.clear_host_mapping = 1'b1; dec.scrub_page = 1'b1; dec.flush_page = 1'b1;
        end
      end
      CMD_ASSIGN_VM: begin
        if (ent.owner == HOST) begin
          if (ent.count == 16'd0) begin
            dec.status = STAT_APPLIED;
            nent.owner = cur.vm; nent.gmap = cur.gfn;
            dec.clear_host_mapping = 1'b1; dec.fetch_contents = 1'b1;
            dec.flush_page = 1'b1;
          end else begin
            dec.status = STAT_FAULT;
          end
        end else if (ent.owner == cur.vm) begin
          if (cur.gfn == ent.gmap || ent.gmap == GFN_NONE) begin
            dec.status = STAT_APPLIED;
            if (ent.count == SMMU_MARK) nent.count = 16'd0;
            if (ent.gmap == GFN_NONE) nent.gmap = cur.gfn;
            dec.flush_page = 1'b1;
          end else begin
            dec.status = STAT_FAULT;
          end
        end else begin
          dec.status = STAT_FAULT;
        end
      end
      CMD_GRANT: begin
        if (ent.owner == cur.vm && ent.count < share_limit) begin
          dec.status = STAT_APPLIED;
          nent.count = ent.count + 16'd1;
        end
      end
      CMD_REVOKE: begin
        if (ent.owner == cur.vm && ent.count != 16'd0) begin
          dec.status = STAT_APPLIED;
          nent.count = ent.count - 16'd1;
          if (ent.count == 16'd1) begin
            dec.clear_host_mapping = 1'b1; dec.fetch_contents = 1'b1;
          end
        end
      end
      CMD_ASSIGN_SMMU: begin
        if (ent.owner == HOST) begin
          if (ent.count == 16'd0) begin
            dec.status = STAT_APPLIED;
            nent.owner = cur.vm; nent.gmap = cur.gfn; nent.count = SMMU_MARK;
            dec.clear_host_mapping = 1'b1;
          end else begin
            dec.status = STAT_FAULT;
          end
        end else if (ent.owner != DEVICE_OWNER) begin
          dec.status = STAT_FAULT;
        end
      end
      CMD_SMMU_MAP: begin
        if (ent.owner == DEVICE_OWNER || (cur.vm == ent.owner && cur.gfn == ent.gmap)) begin
          dec.status = STAT_APPLIED;
          dec.write_smmu_entry = 1'b1;
          if (ent.owner == HOST && ent.count < smmu_ref_limit)
            nent.count = ent.count + 16'd1;
        end else begin
          dec.status = STAT_FAULT;
        end
      end
      CMD_SMMU_UNMAP: begin
        if (ent.owner == HOST && ent.count != 16'd0) begin
          dec.status = STAT_APPLIED;
          nent.count = ent.count - 16'd1;
        end
      end
      default: ;
    endcase
    if (dec.status == STAT_APPLIED && cur.in_range) begin
      dec.owner_after = nent.owner;
      dec.count_after = nent.count;
    end else begin
      dec.owner_after = ent.owner;
      dec.count_after = ent.count;
    end
  end

  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we          = 1'b1;
      ram_waddr       = clr_addr;
      ram_wdata.owner = HOST;
      ram_wdata.count = 16'd0;
      ram_wdata.gmap  = GFN_NONE;
    end else begin
      ram_we    = go && cur.in_range && (dec.status == STAT_APPLIED);
      ram_waddr = cur.idx[AW-1:0];
      ram_wdata = nent;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_item;
    if (go) res <= dec;
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (go) res_valid <= 1'b1;
      else if (pop) res_valid <= 1'b0;
    end
  end

endmodule

### hdl/pot_checker.sv
`timescale 1ns / 1ps
module pot_checker (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  status,
  input logic        write_stage2,
  input logic        stage2_kind,
  input logic        clear_host_mapping,
  input logic        scrub_page,
  input logic        fetch_contents,
  input logic        flush_page,
  input logic        write_smmu_entry
);
  import pot_pkg::*;

  // table sweep follows reset: nothing taken, nothing shown
  a_reset_sweep: assert property (@(posedge clk) rst |=> full && empty)
    else $error("block not held off after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (status == STAT_APPLIED || status == STAT_NOCHANGE ||
                status == STAT_FAULT))
    else $error("undefined status");

  a_quiet_flags: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != STAT_APPLIED) |->
      !(write_stage2 || clear_host_mapping || scrub_page || fetch_contents ||
        flush_page || write_smmu_entry || stage2_kind))
    else $error("request raised without applying");

  a_kind_alone: assert property (@(posedge clk) disable iff (rst)
    (!empty && !write_stage2) |-> !stage2_kind)
    else $error("stage-2 kind without stage-2 write");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty && $stable(status))
    else $error("waiting result dropped or changed");

endmodule

bind page_ownership_tracker_unit pot_checker u_pot_checker (.*);
